// ----- rtl/pmpt_pkg.sv -----
// Shared types, constants and delta arithmetic for the proportional mouse pointer tracker.
// Used by pmpt_axis, pmpt_cfg_regs and the top level; depends on nothing.
package pmpt_pkg;

  localparam int unsigned PotW = 8;
  localparam int unsigned PosW = 10;

  // Register map of the configuration channel
  typedef enum logic [1:0] {
    REG_MAX_X = 2'd0,
    REG_MAX_Y = 2'd1
  } cfg_reg_e;

  localparam logic [PosW-1:0] MAX_X_RESET = 10'd319;
  localparam logic [PosW-1:0] MAX_Y_RESET = 10'd199;

  // Acceleration thresholds on delta magnitude
  localparam logic [4:0] ACCEL_HI_LIMIT = 5'd10;
  localparam logic [4:0] ACCEL_LO_LIMIT = 5'd5;

  typedef logic signed [5:0] delta_t;  // -31..31
  typedef logic signed [8:0] accel_t;  // -155..155

  // 7-bit wrapped difference, noise bit dropped. A negative difference whose
  // upper bits are all ones is treated as no movement.
  function automatic delta_t pot_delta(input logic [PotW-1:0] pot, input logic [PotW-1:0] old);
    logic [PotW-1:0] diff;
    logic [4:0]      half;
    diff = pot - old;
    half = diff[5:1];
    if (!diff[6]) begin
      return $signed({1'b0, half});
    end else if (half == 5'h1f) begin
      return '0;
    end else begin
      return $signed({1'b1, 5'(half + 5'd1)});
    end
  endfunction

  // Scale by 5 above the high limit, by 3 above the low limit.
  function automatic accel_t accelerate(input delta_t d);
    accel_t     w;
    logic [4:0] mag;
    w   = accel_t'(d);
    mag = d[5] ? 5'(-d) : d[4:0];
    if (mag > ACCEL_HI_LIMIT) begin
      return (w <<< 2) + w;
    end else if (mag > ACCEL_LO_LIMIT) begin
      return (w <<< 1) + w;
    end else begin
      return w;
    end
  endfunction

endpackage

// ----- rtl/pmpt_axis.sv -----
// One pointer axis: previous pot reading, delta, acceleration and clamped position.
// The position register doubles as the result register. Depends on pmpt_pkg.
module pmpt_axis (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          subtract_i,
  input  logic [pmpt_pkg::PotW-1:0]     pot_i,
  input  logic [pmpt_pkg::PosW-1:0]     max_i,
  output logic [pmpt_pkg::PosW-1:0]     pos_o
);

  logic [pmpt_pkg::PotW-1:0] last_q;
  logic [pmpt_pkg::PosW-1:0] pos_q, pos_d;
  pmpt_pkg::delta_t          delta;
  pmpt_pkg::accel_t          accel;
  logic signed [11:0]        step_amt;
  logic signed [11:0]        sum;

  always_comb begin
    delta    = pmpt_pkg::pot_delta(pot_i, last_q);
    accel    = pmpt_pkg::accelerate(delta);
    step_amt = subtract_i ? -(12'(accel)) : 12'(accel);
    sum      = $signed({2'b00, pos_q}) + step_amt;
    // clamp to 0..max, also pulls in a position left above a lowered limit
    if (sum[11]) begin
      pos_d = '0;
    end else if (sum[10:0] > {1'b0, max_i}) begin
      pos_d = max_i;
    end else begin
      pos_d = sum[pmpt_pkg::PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      pos_q  <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
      // keep the old reading when nothing moved
      if (delta != '0) begin
        last_q <= pot_i;
      end
    end
  end

  assign pos_o = pos_q;

endmodule

// ----- rtl/pmpt_cfg_regs.sv -----
// Clamp limit registers written through the configuration channel.
// Depends on pmpt_pkg for the register map and reset values.
module pmpt_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [1:0]                wr_index_i,
  input  logic [pmpt_pkg::PosW-1:0] wr_data_i,
  output logic [pmpt_pkg::PosW-1:0] max_x_o,
  output logic [pmpt_pkg::PosW-1:0] max_y_o
);

  logic [pmpt_pkg::PosW-1:0] max_x_q, max_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= pmpt_pkg::MAX_X_RESET;
      max_y_q <= pmpt_pkg::MAX_Y_RESET;
    end else if (wr_en_i) begin
      case (pmpt_pkg::cfg_reg_e'(wr_index_i))
        pmpt_pkg::REG_MAX_X: max_x_q <= wr_data_i;
        pmpt_pkg::REG_MAX_Y: max_y_q <= wr_data_i;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  assign max_x_o = max_x_q;
  assign max_y_o = max_y_q;

endmodule

// ----- rtl/proportional_mouse_pointer_tracker.sv -----
// Top level of the proportional mouse pointer tracker: input register, handshake
// control, clamp limit registers and two axis units.
// Depends on pmpt_pkg, pmpt_axis, pmpt_cfg_regs.
//
//  channel  | direction | payload (low bit up)              | transaction when
//  ---------+-----------+-----------------------------------+--------------------------
//  s_axis   | in        | pot_x[7:0], pot_y[15:8]           | s_axis_tvalid & tready
//  m_axis   | out       | pointer_x[9:0], pointer_y[19:10]  | m_axis_tvalid & tready
//  cfg      | in        | index 0 max_x, 1 max_y; 10b data  | cfg_valid_i & cfg_ready_o
//
// One reading per cycle sustained while the output is not stalled; a result passes
// through the input register and then the position registers in each axis unit.
// Reset clears positions and previous readings, limits go to 319 and 199.
// A stalled output holds; one more reading waits in the input register, then
// s_axis_tready drops. The configuration channel is always ready.
module proportional_mouse_pointer_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // pot_x[7:0], pot_y[15:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // pointer_x[9:0], pointer_y[19:10], zero[23:20]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  logic                      in_valid_q;
  logic [pmpt_pkg::PotW-1:0] pot_x_q, pot_y_q;
  logic                      out_valid_q;
  logic                      advance;
  logic                      in_take;
  logic [pmpt_pkg::PosW-1:0] max_x, max_y;
  logic [pmpt_pkg::PosW-1:0] pos_x, pos_y;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pot_x_q <= s_axis_tdata[7:0];
      pot_y_q <= s_axis_tdata[15:8];
    end
  end

  assign cfg_ready_o = 1'b1;

  pmpt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .max_x_o    (max_x),
    .max_y_o    (max_y)
  );

  // horizontal adds the delta, vertical subtracts it
  pmpt_axis u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .subtract_i (1'b0),
    .pot_i      (pot_x_q),
    .max_i      (max_x),
    .pos_o      (pos_x)
  );

  pmpt_axis u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .subtract_i (1'b1),
    .pot_i      (pot_y_q),
    .max_i      (max_y),
    .pos_o      (pos_y)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, pos_y, pos_x};

endmodule

// ----- rtl/pmpt_checker.sv -----
// Port-level checks for the proportional mouse pointer tracker, bound to the top level.
// Sees only the top-level ports; no package dependency.
module pmpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a new result is raised the cycle after an input transaction; the rise is seen
  // once the output valid register holds it, hence the check looks back past both registers
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a preceding input transaction");

  // input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output is free");

  // a result leaves only by a transaction
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result dropped without a transaction");

endmodule

bind proportional_mouse_pointer_tracker pmpt_checker u_pmpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
